### rtl/core/iofb_pkg.sv
// Package with types and constants of the I/O flush barrier tracker.
package iofb_pkg;

  localparam int unsigned IoSlots    = 64;
  localparam int unsigned FlushSlots = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned IoIdxW     = (IoSlots > 1) ? $clog2(IoSlots) : 1;
  localparam int unsigned FlIdxW     = (FlushSlots > 1) ? $clog2(FlushSlots) : 1;
  localparam int unsigned FlCntW     = $clog2(FlushSlots + 1);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  localparam logic [1:0] ModeStart    = 2'd0;
  localparam logic [1:0] ModeFinish   = 2'd1;
  localparam logic [1:0] ModeFlush    = 2'd2;
  localparam logic [1:0] ModeShutdown = 2'd3;

  localparam logic [1:0] KindSeq     = 2'd0;
  localparam logic [1:0] KindDone    = 2'd1;
  localparam logic [1:0] KindRefused = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] io_tag;
    logic [15:0] flush_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] sequence_res;
    logic [15:0] done_handle;
    logic        last;
  } res_t;

endpackage

### rtl/core/io_flush_barrier_tracker.sv
// Top level of the I/O flush barrier tracker: sequencer, I/O table and flush queue.
// A start or flush scans the I/O table, then decides. A start always answers; a flush
// answers only if no I/O is in flight (done) or the queue is full (refused), else it is
// queued. A finish that hits scans twice, then runs one queue scan per released flush;
// a finish that misses gives no result. Shutdown runs the queue scans only.
// Throughput: one transaction at a time; busy is high until the transaction ends, with its last result if any.
// Reset clears valid bits, counter, queue and sequencer; the receiver cannot stall.
module io_flush_barrier_tracker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  iofb_pkg::req_t req_i,
  output logic           res_valid_o,
  output iofb_pkg::res_t res_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StScan2  = 3'd2;
  localparam logic [2:0] StRel    = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;

  logic [2:0] state_q;
  iofb_pkg::req_t req_q;
  logic [63:0] next_seq_q;

  // I/O table.
  logic [iofb_pkg::IoSlots-1:0] io_valid_q;
  logic [31:0] io_tag_mem [iofb_pkg::IoSlots];
  logic [63:0] io_seq_mem [iofb_pkg::IoSlots];

  // Flush queue, kept compacted as a prefix in arrival order.
  logic [iofb_pkg::FlCntW-1:0] fl_cnt_q;
  logic [63:0] fl_key_q [iofb_pkg::FlushSlots];
  logic [15:0] fl_hdl_q [iofb_pkg::FlushSlots];

  // Scan state and the registered read port of the I/O table.
  logic [iofb_pkg::IoIdxW:0] idx_q;
  logic [iofb_pkg::IoIdxW-1:0] ix;
  logic        rd_go_q, rd_v_q;
  logic [iofb_pkg::IoIdxW-1:0] rd_slot_q;
  logic [31:0] rd_tag_q;
  logic [63:0] rd_seq_q;
  logic        hit_q, free_q, any_q;
  logic [iofb_pkg::IoIdxW-1:0] hit_slot_q, free_slot_q;
  logic [63:0] hit_seq_q, ext_q;
  logic [iofb_pkg::FlIdxW:0] fidx_q;
  logic [iofb_pkg::FlIdxW-1:0] fx;
  logic        best_v_q, elig1_q, elig2_q;
  logic [iofb_pkg::FlIdxW-1:0] best_q;
  logic [iofb_pkg::ResCntW-1:0] nres_q;
  logic        res_valid_q, res_valid_d;
  iofb_pkg::res_t res_q, res_d;

  logic scan_busy, scan_done, fscan_end, fl_full, elig, cand;
  logic rel_emit, rel_last, mem_we;
  logic [iofb_pkg::FlIdxW-1:0] rel_pick;

  assign ix = idx_q[iofb_pkg::IoIdxW-1:0];
  assign fx = fidx_q[iofb_pkg::FlIdxW-1:0];
  assign busy = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  assign scan_busy = (state_q == StScan) || (state_q == StScan2);
  assign scan_done = rd_go_q && (rd_slot_q == iofb_pkg::IoIdxW'(iofb_pkg::IoSlots - 1));
  assign fscan_end = (fidx_q == (iofb_pkg::FlIdxW+1)'(iofb_pkg::FlushSlots - 1));
  assign fl_full = (fl_cnt_q == iofb_pkg::FlCntW'(iofb_pkg::FlushSlots));

  // Candidate flush entry test for the shared compare unit. Without an in-flight
  // bound (any_q low) every waiting flush is eligible.
  assign elig = (fidx_q < (iofb_pkg::FlIdxW+1)'(fl_cnt_q)) &&
                (!any_q || fl_key_q[fx] < ext_q);
  assign cand = elig && (!best_v_q || fl_key_q[fx] < fl_key_q[best_q]);
  assign rel_pick = cand ? fx : best_q;
  assign rel_emit = (state_q == StRel) && fscan_end && (best_v_q || cand);
  // The release is the last one when the result limit is reached or no other
  // eligible entry was seen in this scan.
  assign rel_last = (nres_q == iofb_pkg::ResCntW'(iofb_pkg::MaxResults - 1)) ||
                    !(elig2_q || (elig1_q && elig));
  assign mem_we = (state_q == StDecide) && (req_q.mode == iofb_pkg::ModeStart) &&
                  !hit_q && free_q;

  // Result formation.
  always_comb begin
    res_valid_d = 1'b0;
    res_d = '0;
    if (state_q == StDecide) begin
      if (req_q.mode == iofb_pkg::ModeStart) begin
        res_valid_d = 1'b1;
        res_d.last = 1'b1;
        res_d.kind = iofb_pkg::KindSeq;
        if (hit_q) begin
          res_d.sequence_res = hit_seq_q;
        end else if (free_q) begin
          res_d.sequence_res = next_seq_q;
        end else begin
          res_d.kind = iofb_pkg::KindRefused;
        end
      end else if (req_q.mode == iofb_pkg::ModeFlush && (!any_q || fl_full)) begin
        res_valid_d = 1'b1;
        res_d.last = 1'b1;
        res_d.kind = any_q ? iofb_pkg::KindRefused : iofb_pkg::KindDone;
        res_d.done_handle = req_q.flush_handle;
      end
    end else if (rel_emit) begin
      res_valid_d = 1'b1;
      res_d.kind = iofb_pkg::KindDone;
      res_d.done_handle = fl_hdl_q[rel_pick];
      res_d.last = rel_last;
    end
  end

  // I/O table storage with a registered read port at the scan address.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      io_tag_mem[free_slot_q] <= req_q.io_tag;
      io_seq_mem[free_slot_q] <= next_seq_q;
    end
    rd_tag_q <= io_tag_mem[ix];
    rd_seq_q <= io_seq_mem[ix];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      req_q <= '0;
      io_valid_q <= '0;
      fl_cnt_q <= '0;
      for (int k = 0; k < int'(iofb_pkg::FlushSlots); k++) begin
        fl_key_q[k] <= '0;
        fl_hdl_q[k] <= '0;
      end
      next_seq_q <= '0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      idx_q <= '0;
      fidx_q <= '0;
      nres_q <= '0;
      rd_go_q <= 1'b0;
      rd_v_q <= 1'b0;
      rd_slot_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      any_q <= 1'b0;
      hit_slot_q <= '0;
      free_slot_q <= '0;
      hit_seq_q <= '0;
      ext_q <= '0;
      best_v_q <= 1'b0;
      best_q <= '0;
      elig1_q <= 1'b0;
      elig2_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      res_q <= res_d;
      rd_go_q <= scan_busy && (idx_q < (iofb_pkg::IoIdxW+1)'(iofb_pkg::IoSlots));
      rd_v_q <= io_valid_q[ix];
      rd_slot_q <= ix;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            req_q <= req_i;
            idx_q <= '0;
            hit_q <= 1'b0;
            free_q <= 1'b0;
            any_q <= 1'b0;
            nres_q <= '0;
            fidx_q <= '0;
            best_v_q <= 1'b0;
            elig1_q <= 1'b0;
            elig2_q <= 1'b0;
            if (req_i.mode == iofb_pkg::ModeStart) next_seq_q <= next_seq_q + 64'd1;
            if (req_i.mode == iofb_pkg::ModeShutdown) begin
              state_q <= StRel;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          // Tag match, free slot search, or newest sequence search.
          if (rd_go_q && rd_v_q) begin
            if (req_q.mode == iofb_pkg::ModeFlush) begin
              if (!any_q || rd_seq_q > ext_q) begin
                ext_q <= rd_seq_q;
                any_q <= 1'b1;
              end
            end else if (!hit_q && rd_tag_q == req_q.io_tag) begin
              hit_q <= 1'b1;
              hit_slot_q <= rd_slot_q;
              hit_seq_q <= rd_seq_q;
            end
          end
          if (rd_go_q && !rd_v_q && !free_q) begin
            free_q <= 1'b1;
            free_slot_q <= rd_slot_q;
          end
          idx_q <= idx_q + (iofb_pkg::IoIdxW+1)'(1);
          if (scan_done) state_q <= StDecide;
        end
        StDecide: begin
          unique case (req_q.mode)
            iofb_pkg::ModeStart: begin
              if (mem_we) io_valid_q[free_slot_q] <= 1'b1;
              state_q <= StIdle;
            end
            iofb_pkg::ModeFlush: begin
              if (any_q && !fl_full) begin
                fl_key_q[fl_cnt_q[iofb_pkg::FlIdxW-1:0]] <= ext_q;
                fl_hdl_q[fl_cnt_q[iofb_pkg::FlIdxW-1:0]] <= req_q.flush_handle;
                fl_cnt_q <= fl_cnt_q + iofb_pkg::FlCntW'(1);
              end
              state_q <= StIdle;
            end
            iofb_pkg::ModeFinish: begin
              // Finish: drop the slot, then look for the oldest remaining.
              if (hit_q) begin
                io_valid_q[hit_slot_q] <= 1'b0;
                idx_q <= '0;
                any_q <= 1'b0;
                state_q <= StScan2;
              end else begin
                state_q <= StIdle;
              end
            end
            default: begin
              state_q <= StIdle;
            end
          endcase
        end
        StScan2: begin
          if (rd_go_q && rd_v_q && (!any_q || rd_seq_q < ext_q)) begin
            ext_q <= rd_seq_q;
            any_q <= 1'b1;
          end
          idx_q <= idx_q + (iofb_pkg::IoIdxW+1)'(1);
          if (scan_done) state_q <= StRel;
        end
        StRel: begin
          // Release scan: find the eligible flush with the lowest key (earliest arrival on a tie), emit it, remove it.
          if (fscan_end) begin
            fidx_q <= '0;
            best_v_q <= 1'b0;
            elig1_q <= 1'b0;
            elig2_q <= 1'b0;
            if (rel_emit) begin
              for (int k = 0; k < int'(iofb_pkg::FlushSlots) - 1; k++) begin
                if (k >= int'(rel_pick)) begin
                  fl_key_q[k] <= fl_key_q[k+1];
                  fl_hdl_q[k] <= fl_hdl_q[k+1];
                end
              end
              fl_cnt_q <= fl_cnt_q - iofb_pkg::FlCntW'(1);
              nres_q <= nres_q + iofb_pkg::ResCntW'(1);
              if (rel_last) state_q <= StIdle;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            fidx_q <= fidx_q + (iofb_pkg::FlIdxW+1)'(1);
            if (cand) begin
              best_v_q <= 1'b1;
              best_q <= fx;
            end
            if (elig) begin
              elig1_q <= 1'b1;
              elig2_q <= elig2_q || elig1_q;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // The flush queue never exceeds its size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_cnt_q <= iofb_pkg::FlCntW'(iofb_pkg::FlushSlots))
    else $error("flush queue overflow");
  // No transaction is taken while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("idle before last result");
  // A start always answers after its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecide && req_q.mode == iofb_pkg::ModeStart |=> res_valid_o)
    else $error("start without result");

endmodule
